@@ hw/rtl/ita_pkg.sv @@
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, codes and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int ValueWidth = 64;
  localparam int ModeWidth  = 3;
  localparam int CharWidth  = 8;
  localparam int DigitCount = 16;
  localparam int CntWidth   = $clog2(DigitCount);

  localparam logic [ModeWidth-1:0] MODE_SDEC = 3'd0;
  localparam logic [ModeWidth-1:0] MODE_UDEC = 3'd1;
  localparam logic [ModeWidth-1:0] MODE_HEXL = 3'd2;
  localparam logic [ModeWidth-1:0] MODE_HEXU = 3'd3;

  // ceil(2^35 / 10); (x * RECIP10) >> 35 == x / 10 for any 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RecipShift  = 35;

  localparam logic [CharWidth-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CHAR_X     = 8'h78;
  localparam logic [CharWidth-1:0] CHAR_UA    = 8'h41;
  localparam logic [CharWidth-1:0] CHAR_LA    = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_UPD,
    ST_HEX,
    ST_EMIT_SIGN,
    ST_EMIT_ZERO,
    ST_EMIT_X,
    ST_EMIT_DIGIT
  } state_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] d,
                                                      input logic upper);
    logic [CharWidth-1:0] base;
    base = upper ? CHAR_UA : CHAR_LA;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

@@ hw/rtl/integer_to_ascii_digits_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_core
// Converts a binary value to ASCII text, one character per output request.
//
// Input channel s_axis: one request carries a 64-bit value and a 3-bit mode
// (0 signed decimal, 1 unsigned decimal, 2 hex lowercase, 3 hex uppercase,
// anything else pointer: "0x" then 64-bit lowercase hex). Output channel
// m_axis: one ASCII character per request, most significant first, tlast on
// the final character of each value. No leading zeros; zero gives "0".
// Digits are first extracted least significant first into a 16-entry digit
// buffer, then emitted in reverse. Decimal uses one shared 32x32 reciprocal
// multiplier, with a multiply state then an update state per digit; hex
// shifts one nibble per cycle. s_axis_tready is high only while idle, and
// rises again once the last character sits in the output register. A stalled
// receiver holds the output register and the sequencer waits. Synchronous
// reset empties the output and returns to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [63:0] value, [66:64] mode, [71:67] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] text_char
  output logic        m_axis_tlast    // last
);

  localparam int CW = ita_pkg::CntWidth;

  ita_pkg::state_t state, state_next;

  logic [ita_pkg::ValueWidth-1:0] mag;
  logic [63:0]                    prod;
  logic [3:0]                     dig [ita_pkg::DigitCount];
  logic [CW-1:0]                  cnt;
  logic                           neg;
  logic                           ptr;
  logic                           upper;

  logic [ita_pkg::ValueWidth-1:0] in_value;
  logic [ita_pkg::ModeWidth-1:0]  in_mode;
  logic [31:0]                    low32;
  logic                           accept;
  logic                           out_load;
  logic [7:0]                     out_char;
  logic                           out_last;
  logic                           emitting;

  logic [28:0] quot;
  logic [31:0] quot10;
  logic [31:0] rem;
  logic [ita_pkg::ValueWidth-1:0] mag_shr;
  ita_pkg::state_t first_emit;

  assign in_value = s_axis_tdata[63:0];
  assign in_mode  = s_axis_tdata[66:64];
  assign low32    = in_value[31:0];
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign quot    = prod[63:ita_pkg::RecipShift];
  assign quot10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem     = mag[31:0] - quot10;
  assign mag_shr = mag >> 4;

  assign first_emit = neg ? ita_pkg::ST_EMIT_SIGN :
                      ptr ? ita_pkg::ST_EMIT_ZERO : ita_pkg::ST_EMIT_DIGIT;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ita_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == ita_pkg::MODE_SDEC || in_mode == ita_pkg::MODE_UDEC) begin
            state_next = ita_pkg::ST_DIV_MUL;
          end else begin
            state_next = ita_pkg::ST_HEX;
          end
        end
      end
      ita_pkg::ST_DIV_MUL: state_next = ita_pkg::ST_DIV_UPD;
      ita_pkg::ST_DIV_UPD: begin
        state_next = (quot == '0) ? first_emit : ita_pkg::ST_DIV_MUL;
      end
      ita_pkg::ST_HEX: begin
        if (mag_shr == '0) begin
          state_next = first_emit;
        end
      end
      ita_pkg::ST_EMIT_SIGN: begin
        if (out_load) state_next = ita_pkg::ST_EMIT_DIGIT;
      end
      ita_pkg::ST_EMIT_ZERO: begin
        if (out_load) state_next = ita_pkg::ST_EMIT_X;
      end
      ita_pkg::ST_EMIT_X: begin
        if (out_load) state_next = ita_pkg::ST_EMIT_DIGIT;
      end
      ita_pkg::ST_EMIT_DIGIT: begin
        if (out_load && cnt == '0) state_next = ita_pkg::ST_IDLE;
      end
      default: state_next = ita_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    emitting      = 1'b0;
    out_char      = ita_pkg::CHAR_ZERO;
    out_last      = 1'b0;
    unique case (state)
      ita_pkg::ST_IDLE:      s_axis_tready = 1'b1;
      ita_pkg::ST_EMIT_SIGN: begin
        emitting = 1'b1;
        out_char = ita_pkg::CHAR_MINUS;
      end
      ita_pkg::ST_EMIT_ZERO: begin
        emitting = 1'b1;
        out_char = ita_pkg::CHAR_ZERO;
      end
      ita_pkg::ST_EMIT_X: begin
        emitting = 1'b1;
        out_char = ita_pkg::CHAR_X;
      end
      ita_pkg::ST_EMIT_DIGIT: begin
        emitting = 1'b1;
        out_char = ita_pkg::digit_char(dig[cnt], upper);
        out_last = (cnt == '0);
      end
      default: ;
    endcase
    out_load = emitting && (!m_axis_tvalid || m_axis_tready);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= out_char;
      m_axis_tlast <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ita_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (state)
        ita_pkg::ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
            case (in_mode)
              ita_pkg::MODE_SDEC: begin
                neg   <= low32[31];
                ptr   <= 1'b0;
                upper <= 1'b0;
                mag   <= {32'd0, low32[31] ? (~low32) + 32'd1 : low32};
              end
              ita_pkg::MODE_UDEC: begin
                neg   <= 1'b0;
                ptr   <= 1'b0;
                upper <= 1'b0;
                mag   <= {32'd0, low32};
              end
              ita_pkg::MODE_HEXL: begin
                neg   <= 1'b0;
                ptr   <= 1'b0;
                upper <= 1'b0;
                mag   <= {32'd0, low32};
              end
              ita_pkg::MODE_HEXU: begin
                neg   <= 1'b0;
                ptr   <= 1'b0;
                upper <= 1'b1;
                mag   <= {32'd0, low32};
              end
              default: begin
                neg   <= 1'b0;
                ptr   <= 1'b1;
                upper <= 1'b0;
                mag   <= in_value;
              end
            endcase
          end
        end
        ita_pkg::ST_DIV_MUL: begin
          prod <= mag[31:0] * ita_pkg::RECIP10;
        end
        ita_pkg::ST_DIV_UPD: begin
          dig[cnt] <= rem[3:0];
          mag      <= {35'd0, quot};
          if (quot != '0) cnt <= cnt + 1'b1;
        end
        ita_pkg::ST_HEX: begin
          dig[cnt] <= mag[3:0];
          mag      <= mag_shr;
          if (mag_shr != '0) cnt <= cnt + 1'b1;
        end
        ita_pkg::ST_EMIT_DIGIT: begin
          if (out_load && cnt != '0) cnt <= cnt - 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("ready high right after accepting a value");

  a_dec_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ita_pkg::ST_DIV_UPD) |-> (cnt <= CW'(9)))
    else $error("more than ten decimal digits");

  a_dec_mag_narrow: assert property (@(posedge clk) disable iff (rst)
    (state == ita_pkg::ST_DIV_MUL) |-> (mag[63:32] == '0))
    else $error("decimal magnitude wider than 32 bits");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (state == ita_pkg::ST_IDLE))
    else $error("sequencer busy after last character");

endmodule
